### rtl/haversine_arc_distance_top_assert.svh
// Assertion macros for the haversine arc distance block.
`ifndef HAVERSINE_ARC_DISTANCE_TOP_ASSERT_SVH
`define HAVERSINE_ARC_DISTANCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HAV_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("hav: implication failed");
`define HAV_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("hav: next-cycle check failed");
`else
`define HAV_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define HAV_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### rtl/hav_pkg.sv
`default_nettype none
package hav_pkg;
	localparam int ANGLE_FRAC_BITS = 23;
	localparam int CORDIC_STAGES_DEF = 28;
	localparam int DEG_W = 33;   // degree values and differences
	localparam int ANG_W = 35;   // Q30 angles before reduction
	localparam int CW = 34;      // CORDIC datapath
	localparam int TRIG_W = 32;  // sine/cosine as used by the multipliers
	localparam int H_W = 61;     // haversine term, Q60, 0..1
	localparam int ROOT_W = 31;  // square root of H_W bits
	localparam int RES_W = 33;

	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
	localparam logic signed [ANG_W-1:0] PI_Q30 =
		ANG_W'((PI_Q62 + (64'd1 << 31)) >> 32);
	localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = PI_Q30 <<< 1;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 =
		ANG_W'((PI_Q62 + (64'd1 << 32)) >> 33);
	localparam logic signed [31:0] DEG_RAD_Q36 =
		32'(((PI_Q62 / 64'd180) + (64'd1 << 25)) >> 26);
	localparam logic [30:0] EARTH_R_Q8 = 31'd1631436176;
	localparam logic [RES_W-1:0] METER_MAX = 33'd5125309696;
	localparam logic [H_W-1:0] ONE_Q60 = 61'd1 << 60;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bit_w;
		rem = v;
		res = '0;
		bit_w = 64'd1 << 62;
		for (int n = 0; n < 32; n++) begin
			if (rem >= res + bit_w) begin
				rem = rem - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// truncating unsigned quotient by shift and subtract, for table building
	function automatic logic [63:0] cdiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int n = 63; n >= 0; n--) begin
			rem = {rem[63:0], num[n]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[n] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(atan(2^-i) * 2^30), series in Q62
	function automatic logic [63:0] atan_q30(input int i);
		logic [63:0] sum;
		logic [63:0] term;
		int sh;
		if (i == 0) begin
			return (PI_Q62 + (64'd1 << 33)) >> 34;
		end
		sum = '0;
		for (int t = 0; t < 32; t++) begin
			sh = 62 - i * (2 * t + 1);
			if (sh >= 0) begin
				term = cdiv64(64'd1 << sh, 64'(2 * t + 1));
				if (t[0])
					sum = sum - term;
				else
					sum = sum + term;
			end
		end
		return (sum + (64'd1 << 31)) >> 32;
	endfunction

	// inverse CORDIC gain for n stages, Q30
	function automatic logic [63:0] gain_inv_q30(input int n);
		logic [63:0] k;
		logic [63:0] sq;
		k = 64'd1 << 32;
		for (int i = 0; i < 64; i++) begin
			if (i < n) begin
				sq = 64'd1 << 62;
				if (i <= 31)
					sq = sq + (64'd1 << (62 - 2 * i));
				k = cdiv64(k << 31, isqrt64(sq));
			end
		end
		return (k + 64'd2) >> 2;
	endfunction
endpackage
`default_nettype wire

### rtl/haversine_arc_distance_top.sv
`default_nettype none
`include "haversine_arc_distance_top_assert.svh"
// Haversine great-circle distance. Each s_tdata transfer carries two positions
// (latitude, longitude in degrees * 2^23); the block returns the central angle
// as radians * 2^30, or, with unit_select set, meters * 2^8 on a sphere of
// radius 6372797.560856 m. Fully pipelined: one item per clock while results
// are accepted, through two CORDIC chains of CORDIC_STAGES stages and a
// 31-stage square root. The whole pipeline holds while a result sits on
// m_tdata unaccepted. Write unit_select only when idle.
module haversine_arc_distance_top #(
	parameter int CORDIC_STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// first_latitude[30:0], first_longitude[62:31], second_latitude[93:63],
	// second_longitude[125:94], zero pad
	input  logic [127:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// arc_result[32:0], zero pad
	output logic [39:0] m_tdata
);
	localparam int DW = hav_pkg::DEG_W;
	localparam int AW = hav_pkg::ANG_W;
	localparam int W = hav_pkg::CW;
	localparam int TRW = hav_pkg::TRIG_W;
	localparam int HW = hav_pkg::H_W;
	localparam int RTW = hav_pkg::ROOT_W;
	localparam int RSW = hav_pkg::RES_W;
	localparam logic signed [63:0] ONE_S = 64'sd1 <<< 60;

	logic unit_select_q;
	logic en;

	logic signed [30:0] lat0_in, lat1_in;
	logic signed [31:0] lon0_in, lon1_in;

	logic vld_s1, vld_s2, vld_s3;
	logic signed [DW-1:0] deg_s1 [4];
	logic signed [DW+31:0] prod_s2 [4];
	logic signed [AW-1:0] ang_s3 [4];

	logic sc_valid;
	logic signed [W-1:0] sin_o [4];
	logic signed [W-1:0] cos_o [4];

	logic vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [TRW-1:0] sa, sb, c0, c1;
	logic signed [63:0] sa2_s4, p0_s4, p1_s4;
	logic signed [33:0] p0h, p1h;
	logic signed [67:0] q_full;
	logic signed [63:0] sa2_s5, q_s5;
	logic signed [63:0] hsum_s6;
	logic [HW-1:0] h_s7, rh_s7;
	logic [HW-1:0] sq_in [2];

	logic sq_valid;
	logic [RTW-1:0] sq_out [2];
	logic arc_valid;
	logic signed [W-1:0] arc_z;
	logic signed [W:0] dbl;

	logic vld_s8, vld_s9, vld_s10;
	logic [31:0] ang_s8, ang_s9;
	logic [62:0] mprod_s9;
	logic [62:0] mround;
	logic [RSW-1:0] res_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_select_q <= 1'b0;
		end else if (cfg_we) begin
			unit_select_q <= cfg_wdata;
		end
	end

	// the pipeline advances as a whole unless the output register is stuck
	assign en = !vld_s10 || m_tready;
	assign s_tready = en;

	assign lat0_in = s_tdata[30:0];
	assign lon0_in = s_tdata[62:31];
	assign lat1_in = s_tdata[93:63];
	assign lon1_in = s_tdata[125:94];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= sc_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= arc_valid;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1[0] <= DW'(lat0_in) - DW'(lat1_in);
			deg_s1[1] <= DW'(lon0_in) - DW'(lon1_in);
			deg_s1[2] <= DW'(lat0_in);
			deg_s1[3] <= DW'(lat1_in);
		end
	end

	// degrees to Q30 radians; the differences are halved
	for (genvar k = 0; k < 4; k++) begin : g_rad
		localparam int SH = hav_pkg::ANGLE_FRAC_BITS + 6 + ((k < 2) ? 1 : 0);
		localparam logic signed [DW+31:0] RND = (DW+32)'(1) <<< (SH - 1);
		logic signed [DW+31:0] rnd;
		logic signed [DW+31:0] shf;
		assign rnd = prod_s2[k] + RND;
		assign shf = rnd >>> SH;
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s2[k] <= deg_s1[k] * hav_pkg::DEG_RAD_Q36;
				ang_s3[k] <= shf[AW-1:0];
			end
		end
	end

	hav_sincos #(
		.STAGES(CORDIC_STAGES),
		.LANES(4)
	) u_sincos (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s3),
		.angle(ang_s3),
		.out_valid(sc_valid),
		.sin_out(sin_o),
		.cos_out(cos_o)
	);

	assign sa = sin_o[0][TRW-1:0];
	assign sb = sin_o[1][TRW-1:0];
	assign c0 = cos_o[2][TRW-1:0];
	assign c1 = cos_o[3][TRW-1:0];
	assign p0h = p0_s4[63:30];
	assign p1h = p1_s4[63:30];
	assign q_full = p0h * p1h;

	always_ff @(posedge clk) begin
		if (en) begin
			sa2_s4 <= sa * sa;
			p0_s4 <= c0 * sb;
			p1_s4 <= c1 * sb;
			sa2_s5 <= sa2_s4;
			q_s5 <= q_full[63:0];
			hsum_s6 <= sa2_s5 + q_s5;
			// clamp h to [0, 1] and form 1 - h alongside
			if (hsum_s6 < 0) begin
				h_s7 <= '0;
				rh_s7 <= hav_pkg::ONE_Q60;
			end else if (hsum_s6 > ONE_S) begin
				h_s7 <= hav_pkg::ONE_Q60;
				rh_s7 <= '0;
			end else begin
				h_s7 <= hsum_s6[HW-1:0];
				rh_s7 <= hav_pkg::ONE_Q60 - hsum_s6[HW-1:0];
			end
		end
	end

	assign sq_in[0] = h_s7;
	assign sq_in[1] = rh_s7;

	hav_sqrt #(
		.LANES(2)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s7),
		.v_in(sq_in),
		.out_valid(sq_valid),
		.root_out(sq_out)
	);

	hav_arc #(
		.STAGES(CORDIC_STAGES)
	) u_arc (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(sq_valid),
		.y_in(sq_out[0]),
		.x_in(sq_out[1]),
		.out_valid(arc_valid),
		.z_out(arc_z)
	);

	assign dbl = $signed({arc_z, 1'b0});
	assign mround = mprod_s9 + (63'd1 << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			if (dbl < 0)
				ang_s8 <= '0;
			else if (dbl > hav_pkg::PI_Q30)
				ang_s8 <= hav_pkg::PI_Q30[31:0];
			else
				ang_s8 <= dbl[31:0];
			mprod_s9 <= ang_s8 * hav_pkg::EARTH_R_Q8;
			ang_s9 <= ang_s8;
			if (!unit_select_q)
				res_s10 <= RSW'(ang_s9);
			else if (mround[62:30] > hav_pkg::METER_MAX)
				res_s10 <= hav_pkg::METER_MAX;
			else
				res_s10 <= mround[62:30];
		end
	end

	assign m_tvalid = vld_s10;
	assign m_tdata = {7'd0, res_s10};

	`HAV_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_tvalid && s_tready, vld_s1)
	`HAV_ASSERT_IMPLY(a_h_split, clk, arst_n, vld_s7, (h_s7 + rh_s7) == hav_pkg::ONE_Q60)
	`HAV_ASSERT_IMPLY(a_rad_range, clk, arst_n, m_tvalid && !unit_select_q, res_s10 <= RSW'(hav_pkg::PI_Q30))
	`HAV_ASSERT_IMPLY(a_m_range, clk, arst_n, m_tvalid && unit_select_q, res_s10 <= hav_pkg::METER_MAX)
endmodule
`default_nettype wire

### rtl/hav_sincos.sv
`default_nettype none
module hav_sincos #(
	parameter int STAGES = hav_pkg::CORDIC_STAGES_DEF,
	parameter int LANES = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [hav_pkg::ANG_W-1:0] angle [LANES],
	output logic out_valid,
	output logic signed [hav_pkg::CW-1:0] sin_out [LANES],
	output logic signed [hav_pkg::CW-1:0] cos_out [LANES]
);
	localparam int AW = hav_pkg::ANG_W;
	localparam int W = hav_pkg::CW;
	localparam logic signed [W-1:0] GAIN = W'(hav_pkg::gain_inv_q30(STAGES));

	logic signed [AW-1:0] z_w_s [LANES];
	logic vld_w_s;
	logic signed [W-1:0] x_c [0:STAGES][LANES];
	logic signed [W-1:0] y_c [0:STAGES][LANES];
	logic signed [W-1:0] z_c [0:STAGES][LANES];
	logic flip_c [0:STAGES][LANES];
	logic vld_c [0:STAGES];
	logic vld_o_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_w_s <= 1'b0;
			vld_c[0] <= 1'b0;
			vld_o_s <= 1'b0;
		end else if (en) begin
			vld_w_s <= in_valid;
			vld_c[0] <= vld_w_s;
			vld_o_s <= vld_c[STAGES];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_front
		always_ff @(posedge clk) begin
			if (en) begin
				// wrap into [-pi, pi)
				if (angle[l] >= hav_pkg::PI_Q30)
					z_w_s[l] <= angle[l] - hav_pkg::TWO_PI_Q30;
				else if (angle[l] < -hav_pkg::PI_Q30)
					z_w_s[l] <= angle[l] + hav_pkg::TWO_PI_Q30;
				else
					z_w_s[l] <= angle[l];
				// fold into [-pi/2, pi/2], negate both results later
				x_c[0][l] <= GAIN;
				y_c[0][l] <= '0;
				if (z_w_s[l] > hav_pkg::HALF_PI_Q30) begin
					z_c[0][l] <= W'(z_w_s[l] - hav_pkg::PI_Q30);
					flip_c[0][l] <= 1'b1;
				end else if (z_w_s[l] < -hav_pkg::HALF_PI_Q30) begin
					z_c[0][l] <= W'(z_w_s[l] + hav_pkg::PI_Q30);
					flip_c[0][l] <= 1'b1;
				end else begin
					z_c[0][l] <= W'(z_w_s[l]);
					flip_c[0][l] <= 1'b0;
				end
				sin_out[l] <= flip_c[STAGES][l] ? -y_c[STAGES][l] : y_c[STAGES][l];
				cos_out[l] <= flip_c[STAGES][l] ? -x_c[STAGES][l] : x_c[STAGES][l];
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [W-1:0] ATAN = W'(hav_pkg::atan_q30(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[i+1] <= 1'b0;
			end else if (en) begin
				vld_c[i+1] <= vld_c[i];
			end
		end
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					flip_c[i+1][l] <= flip_c[i][l];
					if (z_c[i][l] >= 0) begin
						x_c[i+1][l] <= x_c[i][l] - (y_c[i][l] >>> i);
						y_c[i+1][l] <= y_c[i][l] + (x_c[i][l] >>> i);
						z_c[i+1][l] <= z_c[i][l] - ATAN;
					end else begin
						x_c[i+1][l] <= x_c[i][l] + (y_c[i][l] >>> i);
						y_c[i+1][l] <= y_c[i][l] - (x_c[i][l] >>> i);
						z_c[i+1][l] <= z_c[i][l] + ATAN;
					end
				end
			end
		end
	end

	assign out_valid = vld_o_s;
endmodule
`default_nettype wire

### rtl/hav_sqrt.sv
`default_nettype none
module hav_sqrt #(
	parameter int LANES = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [hav_pkg::H_W-1:0] v_in [LANES],
	output logic out_valid,
	output logic [hav_pkg::ROOT_W-1:0] root_out [LANES]
);
	localparam int VW = hav_pkg::H_W;
	localparam int RW = hav_pkg::ROOT_W;
	localparam int TW = 2 * RW + 2;

	// one root bit per stage, MSB first; rem holds v - root^2
	logic [VW-1:0] rem_c [0:RW][LANES];
	logic [RW-1:0] root_c [0:RW][LANES];
	logic vld_c [0:RW];

	assign vld_c[0] = in_valid;
	for (genvar l = 0; l < LANES; l++) begin : g_in
		assign rem_c[0][l] = v_in[l];
		assign root_c[0][l] = '0;
		assign root_out[l] = root_c[RW][l];
	end

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[k+1] <= 1'b0;
			end else if (en) begin
				vld_c[k+1] <= vld_c[k];
			end
		end
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [TW-1:0] trial;
			assign trial = (TW'(root_c[k][l]) << (B + 1)) + (TW'(1) << (2 * B));
			always_ff @(posedge clk) begin
				if (en) begin
					if (TW'(rem_c[k][l]) >= trial) begin
						rem_c[k+1][l] <= VW'(TW'(rem_c[k][l]) - trial);
						root_c[k+1][l] <= root_c[k][l] | (RW'(1) << B);
					end else begin
						rem_c[k+1][l] <= rem_c[k][l];
						root_c[k+1][l] <= root_c[k][l];
					end
				end
			end
		end
	end

	assign out_valid = vld_c[RW];
endmodule
`default_nettype wire

### rtl/hav_arc.sv
`default_nettype none
module hav_arc #(
	parameter int STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [hav_pkg::ROOT_W-1:0] y_in,
	input  logic [hav_pkg::ROOT_W-1:0] x_in,
	output logic out_valid,
	output logic signed [hav_pkg::CW-1:0] z_out
);
	localparam int W = hav_pkg::CW;

	logic signed [W-1:0] x_c [0:STAGES];
	logic signed [W-1:0] y_c [0:STAGES];
	logic signed [W-1:0] z_c [0:STAGES];
	logic vld_c [0:STAGES];

	assign x_c[0] = W'(x_in);
	assign y_c[0] = W'(y_in);
	assign z_c[0] = '0;
	assign vld_c[0] = in_valid;

	// vectoring: drive y to zero, accumulate the angle
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [W-1:0] ATAN = W'(hav_pkg::atan_q30(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[i+1] <= 1'b0;
			end else if (en) begin
				vld_c[i+1] <= vld_c[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_c[i] >= 0) begin
					x_c[i+1] <= x_c[i] + (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] - (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] + ATAN;
				end else begin
					x_c[i+1] <= x_c[i] - (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] + (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] - ATAN;
				end
			end
		end
	end

	assign out_valid = vld_c[STAGES];
	assign z_out = z_c[STAGES];
endmodule
`default_nettype wire
